// ----- design/per_source_reorder_window_receiver_defines.svh -----
// ----------------------------------------------------------------------------
// per_source_reorder_window_receiver_defines
// Assertion macros shared by the reorder receiver.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_REORDER_WINDOW_RECEIVER_DEFINES_SVH
`define PER_SOURCE_REORDER_WINDOW_RECEIVER_DEFINES_SVH

// Assert that a condition implies a consequence on the same edge.
`define PSRW_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies a consequence on the next edge.
`define PSRW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/psrw_pkg.sv -----
// ----------------------------------------------------------------------------
// psrw_pkg
// Types and constants of the reorder window receiver.
// ----------------------------------------------------------------------------
package psrw_pkg;

  localparam int unsigned Sources  = 8;
  localparam int unsigned Window   = 16;
  localparam int unsigned SlotW    = $clog2(Sources);
  localparam int unsigned CntW     = $clog2(Sources + 1);
  localparam int unsigned OffW     = $clog2(Window);
  localparam int unsigned OffCntW  = $clog2(Window + 1);
  localparam int unsigned TagAddrW = $clog2(Sources * Window);

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD,
    ST_READ,
    ST_EMIT,
    ST_ACK
  } state_e;

  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] source_port_number;
    logic [31:0] sequence_req;
    logic        syn_flag;
    logic [7:0]  packet_tag;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  source_slot;
    logic [31:0] sequence_value;
    logic [7:0]  tag_out;
    logic        last;
  } out_word_t;

endpackage

// ----- design/psrw_if.sv -----
// ----------------------------------------------------------------------------
// psrw_if
// Valid/ready channels carrying one in_word_t or one out_word_t word.
// ----------------------------------------------------------------------------
interface psrw_in_if;
  logic                valid;
  logic                ready;
  psrw_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psrw_out_if;
  logic                valid;
  logic                ready;
  psrw_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/per_source_reorder_window_receiver.sv -----
// ----------------------------------------------------------------------------
// per_source_reorder_window_receiver
// Reliable-datagram receiver with a reorder window for each source.
// ----------------------------------------------------------------------------
// One packet word is taken at a time, and the input is not ready again until
// the last result word of that packet has been loaded. The source table is
// searched one slot a cycle, while no result word waits on out_o, by a single
// address/port comparator: the search steps from slot 0 up to a hit, and a
// miss steps through every used slot before it ends. A packet that is not
// rejected is then held; each released packet takes a tag memory read, then
// output, and the ack a final bitmap check, then output. An in-order packet
// from slot 0 with nothing else held is released at once. A result word still
// waiting on out_o stalls the search, the releases and the ack. The tag store
// has one write port and one registered read port.
`include "per_source_reorder_window_receiver_defines.svh"

module per_source_reorder_window_receiver (
  input  logic clk_i,
  input  logic rst_ni,
  psrw_in_if.sink    in_i,
  psrw_out_if.source out_o
);

  psrw_pkg::state_e state_q, state_d;
  psrw_pkg::in_word_t pkt_q;

  logic [31:0] slot_addr_q [psrw_pkg::Sources];
  logic [15:0] slot_port_q [psrw_pkg::Sources];
  logic [31:0] exp_q       [psrw_pkg::Sources];
  logic [psrw_pkg::Window-1:0] bmp_q [psrw_pkg::Sources];
  logic [psrw_pkg::CntW-1:0] used_q;
  // Ring base of each slot's tag window; avoids shifting the tag store.
  logic [psrw_pkg::OffW-1:0] base_q [psrw_pkg::Sources];
  logic [7:0] tag_mem [psrw_pkg::Sources * psrw_pkg::Window];
  logic [7:0] rd_q;

  logic [psrw_pkg::CntW-1:0] idx_q;
  logic [psrw_pkg::SlotW-1:0] slot_q;
  logic [psrw_pkg::OffCntW-1:0] n_q;
  psrw_pkg::out_word_t out_q;
  logic out_v_q;

  logic [psrw_pkg::SlotW-1:0] idx_s;
  logic hit, at_end;
  logic [31:0] off;
  assign idx_s  = idx_q[psrw_pkg::SlotW-1:0];
  assign at_end = (idx_q >= used_q);
  assign hit    = !at_end && slot_addr_q[idx_s] == pkt_q.source_address
                  && slot_port_q[idx_s] == pkt_q.source_port_number;
  assign off    = pkt_q.sequence_req - exp_q[slot_q];
  logic in_win;
  assign in_win = off < 32'(psrw_pkg::Window);
  logic [psrw_pkg::OffW-1:0] woff;
  assign woff = off[psrw_pkg::OffW-1:0] + base_q[slot_q];
  logic reject;
  assign reject = at_end && (!pkt_q.syn_flag
                  || used_q >= psrw_pkg::CntW'(psrw_pkg::Sources));

  assign in_i.ready  = (state_q == psrw_pkg::ST_IDLE);
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // A new result word is loaded only when the output register is free.
  logic load_out;
  always_comb begin
    load_out = 1'b0;
    if (!out_v_q || out_o.ready) begin
      case (state_q)
        psrw_pkg::ST_SEARCH: load_out = !hit && reject;
        psrw_pkg::ST_EMIT:   load_out = 1'b1;
        psrw_pkg::ST_ACK:    load_out = 1'b1;
        default:             load_out = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psrw_pkg::ST_IDLE:   if (in_i.valid) state_d = psrw_pkg::ST_SEARCH;
      psrw_pkg::ST_SEARCH: begin
        if (!out_v_q || out_o.ready) begin
          if (hit) state_d = psrw_pkg::ST_HOLD;
          else if (at_end) begin
            if (reject) state_d = psrw_pkg::ST_IDLE;
            else state_d = psrw_pkg::ST_HOLD;
          end
        end
      end
      psrw_pkg::ST_HOLD:   state_d = psrw_pkg::ST_READ;
      psrw_pkg::ST_READ: begin
        if (bmp_q[slot_q][0] && n_q < psrw_pkg::OffCntW'(psrw_pkg::Window))
          state_d = psrw_pkg::ST_EMIT;
        else state_d = psrw_pkg::ST_ACK;
      end
      psrw_pkg::ST_EMIT:   if (!out_v_q || out_o.ready) state_d = psrw_pkg::ST_READ;
      psrw_pkg::ST_ACK:    if (!out_v_q || out_o.ready) state_d = psrw_pkg::ST_IDLE;
      default:             state_d = psrw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == psrw_pkg::ST_HOLD && in_win
        && !bmp_q[slot_q][off[psrw_pkg::OffW-1:0]]) begin
      tag_mem[{slot_q, woff}] <= pkt_q.packet_tag;
    end
    rd_q <= tag_mem[{slot_q, base_q[slot_q]}];
    if (state_q == psrw_pkg::ST_IDLE && in_i.valid) pkt_q <= in_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psrw_pkg::ST_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
      slot_q  <= '0;
      n_q     <= '0;
      out_v_q <= 1'b0;
      out_q   <= '0;
      for (int i = 0; i < psrw_pkg::Sources; i++) begin
        slot_addr_q[i] <= '0;
        slot_port_q[i] <= '0;
        exp_q[i]       <= '0;
        bmp_q[i]       <= '0;
        base_q[i]      <= '0;
      end
    end else begin
      state_q <= state_d;
      out_v_q <= load_out || (out_v_q && !out_o.ready);
      case (state_q)
        psrw_pkg::ST_IDLE: begin
          idx_q <= '0;
          n_q   <= '0;
        end
        psrw_pkg::ST_SEARCH: begin
          if (!out_v_q || out_o.ready) begin
            if (hit) slot_q <= idx_s;
            else if (at_end) begin
              if (reject) begin
                out_q   <= '{psrw_pkg::KIND_REJECT, 3'd0, pkt_q.sequence_req,
                             pkt_q.packet_tag, 1'b1};
              end else begin
                slot_q              <= used_q[psrw_pkg::SlotW-1:0];
                used_q              <= used_q + 1'b1;
                slot_addr_q[used_q[psrw_pkg::SlotW-1:0]] <= pkt_q.source_address;
                slot_port_q[used_q[psrw_pkg::SlotW-1:0]] <= pkt_q.source_port_number;
                exp_q[used_q[psrw_pkg::SlotW-1:0]]       <= pkt_q.sequence_req;
                bmp_q[used_q[psrw_pkg::SlotW-1:0]]       <= '0;
              end
            end else idx_q <= idx_q + 1'b1;
          end
        end
        psrw_pkg::ST_HOLD: begin
          if (in_win) bmp_q[slot_q][off[psrw_pkg::OffW-1:0]] <= 1'b1;
        end
        psrw_pkg::ST_EMIT: begin
          if (!out_v_q || out_o.ready) begin
            out_q   <= '{psrw_pkg::KIND_DELIVER, 3'(slot_q), exp_q[slot_q], rd_q, 1'b0};
            exp_q[slot_q]  <= exp_q[slot_q] + 32'd1;
            bmp_q[slot_q]  <= bmp_q[slot_q] >> 1;
            base_q[slot_q] <= base_q[slot_q] + 1'b1;
            n_q            <= n_q + 1'b1;
          end
        end
        psrw_pkg::ST_ACK: begin
          if (!out_v_q || out_o.ready) begin
            out_q   <= '{psrw_pkg::KIND_ACK, 3'(slot_q), exp_q[slot_q], 8'd0, 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  `PSRW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_v_q && !out_o.ready, out_v_q && $stable(out_q))
  `PSRW_ASSERT_IMPL(a_used_max, clk_i, rst_ni, 1'b1, used_q <= psrw_pkg::CntW'(psrw_pkg::Sources))
  `PSRW_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_i.ready, state_q == psrw_pkg::ST_IDLE)

endmodule
